// ===== rtl/acta_pkg.sv =====
package acta_pkg;

  // Widths of the fixed-point formats.
  localparam int SAMPLE_W    = 16;
  localparam int AXIS_W      = 17;
  localparam int MAG_W       = 16;
  localparam int FRAC_SHIFT  = 24;
  localparam int XY_W        = 44;
  localparam int Z_W         = 28;
  localparam int V_W         = 30;
  localparam int ANGLE_W     = 15;
  localparam int ROUND_SHIFT = 13;
  localparam int TABLE_LEN   = 24;

  // 90 degrees in 2^-20 degree units, with the rounding half already added.
  localparam logic signed [V_W-1:0] RIGHT_ROUNDED = V_W'(94371840 + 4096);
  localparam logic [ANGLE_W-1:0]    MAX_ANGLE     = ANGLE_W'(23040);
  localparam logic signed [SAMPLE_W-1:0] ZERO_OFFSET_RST = SAMPLE_W'(5496);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;
  } in_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] xz_angle;
    logic [ANGLE_W-1:0] yz_angle;
    logic [ANGLE_W-1:0] xy_angle;
    logic               xz_valid;
    logic               yz_valid;
    logic               xy_valid;
  } out_res_t;

  // One angle with its valid flag, as one tilt lane delivers it.
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               ok;
  } tilt_res_t;

  // atan(2^-i) in degrees times 2^20, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_units(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = Z_W'(47185920);
      1:  r = Z_W'(27855475);
      2:  r = Z_W'(14718068);
      3:  r = Z_W'(7471121);
      4:  r = Z_W'(3750058);
      5:  r = Z_W'(1876857);
      6:  r = Z_W'(938658);
      7:  r = Z_W'(469357);
      8:  r = Z_W'(234682);
      9:  r = Z_W'(117342);
      10: r = Z_W'(58671);
      11: r = Z_W'(29335);
      12: r = Z_W'(14668);
      13: r = Z_W'(7334);
      14: r = Z_W'(3667);
      15: r = Z_W'(1833);
      16: r = Z_W'(917);
      17: r = Z_W'(458);
      18: r = Z_W'(229);
      19: r = Z_W'(115);
      20: r = Z_W'(57);
      21: r = Z_W'(29);
      22: r = Z_W'(14);
      23: r = Z_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/acta_tilt.sv =====
module acta_tilt
  import acta_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AXIS_W-1:0] num,
  input  logic signed [AXIS_W-1:0] den,
  output tilt_res_t                res
);

  // How the final stage forms the angle.
  typedef enum logic [1:0] {
    K_CORDIC,
    K_ZERO,
    K_FULL,
    K_NONE
  } kind_t;

  logic signed [XY_W-1:0] x_r    [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] y_r    [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  z_r    [CORDIC_STAGES+1];
  logic                   neg_r  [CORDIC_STAGES+1];
  kind_t                  kind_r [CORDIC_STAGES+1];

  logic signed [AXIS_W-1:0] num_abs;
  logic signed [AXIS_W-1:0] den_abs;
  logic [MAG_W-1:0]         num_mag;
  logic [MAG_W-1:0]         den_mag;
  kind_t                    kind_nxt;

  // Magnitudes of both operands and the special cases of a zero denominator.
  always_comb begin
    num_abs = num[AXIS_W-1] ? -num : num;
    den_abs = den[AXIS_W-1] ? -den : den;
    num_mag = num_abs[MAG_W-1:0];
    den_mag = den_abs[MAG_W-1:0];
    if (den != '0) begin
      kind_nxt = K_CORDIC;
    end else if (num == '0) begin
      kind_nxt = K_NONE;
    end else if (num[AXIS_W-1]) begin
      kind_nxt = K_FULL;
    end else begin
      kind_nxt = K_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= {{(XY_W-MAG_W-FRAC_SHIFT){1'b0}}, den_mag, {FRAC_SHIFT{1'b0}}};
      y_r[0]    <= {{(XY_W-MAG_W-FRAC_SHIFT){1'b0}}, num_mag, {FRAC_SHIFT{1'b0}}};
      z_r[0]    <= '0;
      neg_r[0]  <= num[AXIS_W-1] ^ den[AXIS_W-1];
      kind_r[0] <= kind_nxt;
    end
  end

  // One vectoring rotation per register stage; the residual y drives the turn.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][XY_W-1]) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_units(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_units(i);
        end
        neg_r[i+1]  <= neg_r[i];
        kind_r[i+1] <= kind_r[i];
      end
    end
  end

  logic signed [V_W-1:0]     z_ext;
  logic signed [V_W-1:0]     v;
  logic [V_W-ROUND_SHIFT-2:0] q;
  tilt_res_t                 res_nxt;
  tilt_res_t                 res_r;

  // Subtract the angle from 90 degrees, round to 1/128 degree and clamp.
  always_comb begin
    z_ext = {{(V_W-Z_W){z_r[CORDIC_STAGES][Z_W-1]}}, z_r[CORDIC_STAGES]};
    v     = neg_r[CORDIC_STAGES] ? RIGHT_ROUNDED + z_ext : RIGHT_ROUNDED - z_ext;
    q     = v[V_W-2:ROUND_SHIFT];
    res_nxt.ok = 1'b1;
    case (kind_r[CORDIC_STAGES])
      K_CORDIC: begin
        if (v[V_W-1]) begin
          res_nxt.angle = '0;
        end else if (q > (V_W-ROUND_SHIFT-1)'(MAX_ANGLE)) begin
          res_nxt.angle = MAX_ANGLE;
        end else begin
          res_nxt.angle = q[ANGLE_W-1:0];
        end
      end
      K_ZERO: begin
        res_nxt.angle = '0;
      end
      K_FULL: begin
        res_nxt.angle = MAX_ANGLE;
      end
      default: begin
        res_nxt.angle = '0;
        res_nxt.ok    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/accel_tilt_angles.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_req_t: x, y, z samples
// out_      output     out_valid/out_stall  out_res_t: three angles, three flags
// cfg_      input      cfg_we               zero_offset register
//
// A request passes CORDIC_STAGES + 3 registers: offset, operand setup, one per rotation
// and rounding. A new request may enter every cycle unless the pipeline is held;
// the three angle lanes run side by side.
// The whole pipeline holds while a result waits under out_stall, so nothing is lost.
// Reset clears the valid bits and loads the zero offset with its default.
module accel_tilt_angles
  import acta_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_req_t                    in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_res_t                   out_data,
  input  logic                       cfg_we,
  input  logic signed [SAMPLE_W-1:0] cfg_zero_offset
);

  localparam int LATENCY = CORDIC_STAGES + 3;

  logic                       en;
  logic signed [SAMPLE_W-1:0] zero_offset_r;
  logic                       vld_r [LATENCY];
  logic signed [AXIS_W-1:0]   x_r;
  logic signed [AXIS_W-1:0]   y_r;
  logic signed [AXIS_W-1:0]   z_r;
  logic signed [AXIS_W-1:0]   off_ext;
  tilt_res_t                  xz_res;
  tilt_res_t                  yz_res;
  tilt_res_t                  xy_res;

  // The pipeline advances unless a finished result is held back.
  assign en       = !(vld_r[LATENCY-1] && out_stall);
  assign in_stall = !en;

  // Zero offset register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= ZERO_OFFSET_RST;
    end else if (cfg_we) begin
      zero_offset_r <= cfg_zero_offset;
    end
  end

  // Valid bits that travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LATENCY; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Remove the zero-g offset from each axis.
  assign off_ext = {zero_offset_r[SAMPLE_W-1], zero_offset_r};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= {in_data.x_sample[SAMPLE_W-1], in_data.x_sample} - off_ext;
      y_r <= {in_data.y_sample[SAMPLE_W-1], in_data.y_sample} - off_ext;
      z_r <= {in_data.z_sample[SAMPLE_W-1], in_data.z_sample} - off_ext;
    end
  end

  // Three angle lanes.
  acta_tilt #(.CORDIC_STAGES(CORDIC_STAGES)) u_xz (
    .clk (clk),
    .en  (en),
    .num (x_r),
    .den (z_r),
    .res (xz_res)
  );

  acta_tilt #(.CORDIC_STAGES(CORDIC_STAGES)) u_yz (
    .clk (clk),
    .en  (en),
    .num (y_r),
    .den (z_r),
    .res (yz_res)
  );

  acta_tilt #(.CORDIC_STAGES(CORDIC_STAGES)) u_xy (
    .clk (clk),
    .en  (en),
    .num (x_r),
    .den (y_r),
    .res (xy_res)
  );

  assign out_valid         = vld_r[LATENCY-1];
  assign out_data.xz_angle = xz_res.angle;
  assign out_data.yz_angle = yz_res.angle;
  assign out_data.xy_angle = xy_res.angle;
  assign out_data.xz_valid = xz_res.ok;
  assign out_data.yz_valid = yz_res.ok;
  assign out_data.xy_valid = xy_res.ok;

  // Input is held back only while a result waits at the output.
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // When x and z and y are all zero, the x/y angle must be flagged too.
  a_xy_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.xz_valid && !out_data.yz_valid) |-> !out_data.xy_valid)
    else $error("xy angle flagged valid with all axes zero");

  // Angles stay within 180 degrees.
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.xz_angle <= MAX_ANGLE && out_data.yz_angle <= MAX_ANGLE
                   && out_data.xy_angle <= MAX_ANGLE))
    else $error("angle above 180 degrees");

  // A result register emptied by reset must not show a valid result straight after reset.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import acta_pkg::*;

  localparam int STAGES     = 16;
  localparam int DEPTH      = STAGES + 3;
  localparam int SETTLE     = DEPTH + 6;
  localparam int PHASE_REQS = 150;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 60;

  // Fixed-point constants of the angle arithmetic, in units of 2^-20 degree.
  localparam int      SHIFT_UP    = 24;
  localparam longint  RIGHT_UNITS = 94371840;
  localparam longint  HALF_LSB    = 4096;
  localparam int      LSB_SHIFT   = 13;
  localparam int      ANGLE_TOP   = 23040;
  localparam longint  ATAN_DEG20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  in_req_t                    in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_res_t                   out_data;
  logic                       cfg_we = 1'b0;
  logic signed [SAMPLE_W-1:0] cfg_zero_offset = ZERO_OFFSET_RST;

  // Predictor copy of the offset register.
  logic signed [SAMPLE_W-1:0] offset_now = ZERO_OFFSET_RST;

  in_req_t  pending_reqs[$];
  out_res_t expected_angles[$];
  bit       req_taken = 1'b0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  accel_tilt_angles #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_zero_offset(cfg_zero_offset)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One angle lane: 90 degrees minus atan(num/den), rounded to 1/128 degree.
  function automatic tilt_res_t tilt_lane(input int num, input int den);
    tilt_res_t r;
    longint    cx, cy, acc, dx, dy, v;
    bit        flip;
    int        i;
    r.ok = 1'b1;
    r.angle = '0;
    if (den == 0) begin
      if (num > 0) r.angle = '0;
      else if (num < 0) r.angle = ANGLE_W'(ANGLE_TOP);
      else r.ok = 1'b0;
      return r;
    end
    flip = (num < 0) != (den < 0);
    cx = (den < 0) ? -den : den;
    cy = (num < 0) ? -num : num;
    cx = cx <<< SHIFT_UP;
    cy = cy <<< SHIFT_UP;
    acc = 0;
    // Vectoring rotations drive the y component toward zero.
    for (i = 0; i < STAGES && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += ATAN_DEG20[i];
      end else begin
        cx -= dx;
        cy += dy;
        acc -= ATAN_DEG20[i];
      end
    end
    v = flip ? RIGHT_UNITS + acc : RIGHT_UNITS - acc;
    v += HALF_LSB;
    if (v < 0) begin
      r.angle = '0;
    end else begin
      v = v >>> LSB_SHIFT;
      r.angle = (v > ANGLE_TOP) ? ANGLE_W'(ANGLE_TOP) : v[ANGLE_W-1:0];
    end
    return r;
  endfunction

  // Expected result for one request under the current offset.
  function automatic out_res_t predict_angles(input in_req_t r);
    int        ax, ay, az;
    tilt_res_t xz, yz, xy;
    out_res_t  o;
    ax = $signed(r.x_sample) - $signed(offset_now);
    ay = $signed(r.y_sample) - $signed(offset_now);
    az = $signed(r.z_sample) - $signed(offset_now);
    xz = tilt_lane(ax, az);
    yz = tilt_lane(ay, az);
    xy = tilt_lane(ax, ay);
    o.xz_angle = xz.angle;
    o.yz_angle = yz.angle;
    o.xy_angle = xy.angle;
    o.xz_valid = xz.ok;
    o.yz_valid = yz.ok;
    o.xy_valid = xy.ok;
    return o;
  endfunction

  function automatic in_req_t mk_req(input int x, input int y, input int z);
    in_req_t r;
    r.x_sample = x[SAMPLE_W-1:0];
    r.y_sample = y[SAMPLE_W-1:0];
    r.z_sample = z[SAMPLE_W-1:0];
    return r;
  endfunction

  // Random request: raw noise, readings near zero-g, small tilts or rail values.
  function automatic in_req_t random_request();
    int vals[3];
    int kind;
    int a;
    kind = $urandom_range(0, 9);
    for (a = 0; a < 3; a++) begin
      if (kind <= 3) begin
        vals[a] = $urandom;
      end else if (kind <= 6) begin
        if ($urandom_range(0, 1))
          vals[a] = int'(offset_now) + int'($urandom_range(0, 6)) - 3;
        else
          vals[a] = $urandom;
      end else if (kind <= 8) begin
        vals[a] = int'(offset_now) + int'($urandom_range(0, 128)) - 64;
      end else begin
        case ($urandom_range(0, 2))
          0: vals[a] = -32768;
          1: vals[a] = 32767;
          default: vals[a] = int'(offset_now);
        endcase
      end
    end
    return mk_req(vals[0], vals[1], vals[2]);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Wait until every request has gone through, then let the pipeline settle.
  // The check runs at the rising edge, where the driver's signals are stable.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_offset(input logic signed [SAMPLE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_zero_offset <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    offset_now = v;
  endtask

  // Request driver: a new request is offered once the last one was taken.
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Result receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin : monitor
    out_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(predict_angles(in_data));
        req_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_angles.pop_front();
          check_field("xz_angle", want.xz_angle, out_data.xz_angle);
          check_field("yz_angle", want.yz_angle, out_data.yz_angle);
          check_field("xy_angle", want.xy_angle, out_data.xy_angle);
          check_field("xz_valid", want.xz_valid, out_data.xz_valid);
          check_field("yz_valid", want.yz_valid, out_data.yz_valid);
          check_field("xy_valid", want.xy_valid, out_data.xy_valid);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("accel_tilt_angles test failed");
      $finish;
    end
  end

  initial begin
    int o;
    int phase;
    int n;
    o = 5496;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The sender idles lightly and the receiver heavily first.
    send_idle_pct = 18;
    stall_pct = 84;

    // Directed requests under the reset offset: zero operands, sign cases, rails.
    pending_reqs.push_back(mk_req(o, o, o));
    pending_reqs.push_back(mk_req(o + 100, o + 50, o));
    pending_reqs.push_back(mk_req(o - 100, o - 50, o));
    pending_reqs.push_back(mk_req(o, o, o + 10));
    pending_reqs.push_back(mk_req(o, o, o - 10));
    pending_reqs.push_back(mk_req(o + 1000, o - 1000, o + 1000));
    pending_reqs.push_back(mk_req(32767, o + 1, o + 1));
    pending_reqs.push_back(mk_req(-32768, -32768, -32768));
    pending_reqs.push_back(mk_req(32767, -32768, o + 1));
    pending_reqs.push_back(mk_req(o + 1, o - 1, -32768));
    pending_reqs.push_back(mk_req(0, 0, 0));
    wait_drained();

    // Largest negative axis values.
    write_offset(16'sd32767);
    pending_reqs.push_back(mk_req(-32768, -32768, -32768));
    pending_reqs.push_back(mk_req(-32768, 32767, -32767));
    pending_reqs.push_back(mk_req(32767, 32767, -32768));
    wait_drained();

    // Largest positive axis values.
    write_offset(-16'sd32768);
    pending_reqs.push_back(mk_req(32767, 32767, 32767));
    pending_reqs.push_back(mk_req(32767, -32768, -32767));
    wait_drained();

    // Random phases, each under its own offset, with the idling pattern changed every two phases.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_offset(16'sd0);
        1: write_offset(-16'sd32768);
        2: write_offset(16'sd32767);
        default: write_offset(SAMPLE_W'($urandom));
      endcase
      if (phase < 2) begin
        send_idle_pct = 18;
        stall_pct = 84;
      end else if (phase < 4) begin
        send_idle_pct = 84;
        stall_pct = 18;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      for (n = 0; n < PHASE_REQS; n++)
        pending_reqs.push_back(random_request());
      // Back up the pipeline while requests keep coming at full rate.
      if (phase == 4)
        hold_req = 1'b1;
      wait_drained();
    end

    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("accel_tilt_angles test passed");
    end else begin
      $display("accel_tilt_angles test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/acta_pkg.sv
rtl/acta_tilt.sv
rtl/accel_tilt_angles.sv
bench/testbench.sv
